>>> rtl/econet_handshake_engine_defines.svh
// ----------------------------------------------------------------------------
// econet handshake engine assertion macros
// shared property wrappers for the rtl checks
// ----------------------------------------------------------------------------
`ifndef ECONET_HANDSHAKE_ENGINE_DEFINES_SVH
`define ECONET_HANDSHAKE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EHE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define EHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ehe_pkg.sv
// ----------------------------------------------------------------------------
// ehe_pkg
// types and constants of the econet handshake engine
// ----------------------------------------------------------------------------
package ehe_pkg;

    localparam logic [15:0] FULL_HDR_LEN  = 16'd6;
    localparam logic [15:0] SHORT_HDR_LEN = 16'd4;
    localparam logic [15:0] PEEK_LEN      = SHORT_HDR_LEN + 16'd4;
    localparam logic [15:0] BCAST_ADDR    = 16'hFFFF;
    localparam logic [7:0]  STATION_BCAST = 8'hFF;
    localparam logic [31:0] PEEK_DATA     = 32'h2A00_0001;

    localparam logic [7:0]  IP_PORT_RST   = 8'd210;
    localparam logic [7:0]  IMM_PORT_RST  = 8'd0;
    localparam logic [7:0]  PEEK_CTL_RST  = 8'd136;
    localparam logic [15:0] MY_ADDR_RST   = 16'd0;

    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MY_ADDR  = 2'd0,
        REG_IP_PORT  = 2'd1,
        REG_IMM_PORT = 2'd2,
        REG_PEEK_CTL = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0,
        REQ_IDLE  = 2'd1,
        REQ_TX    = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_UNKNOWN    = 3'd0,
        ST_IDLE       = 3'd1,
        ST_SCOUT_RCVD = 3'd2,
        ST_SCOUT_SENT = 3'd3,
        ST_DATA_SENT  = 3'd4,
        ST_IMMED_SENT = 3'd5,
        ST_DONE       = 3'd6
    } t_state;

    typedef enum logic [3:0] {
        ACT_IGNORED       = 4'd0,
        ACT_DROP          = 4'd1,
        ACT_ACK           = 4'd2,
        ACT_PEEK_REPLY    = 4'd3,
        ACT_DELIVER_BCAST = 4'd4,
        ACT_DELIVER_PKT   = 4'd5,
        ACT_SCOUT         = 4'd6,
        ACT_IMMEDIATE     = 4'd7,
        ACT_BCAST         = 4'd8,
        ACT_DATA          = 4'd9,
        ACT_COMPLETE      = 4'd10,
        ACT_RETRY         = 4'd11,
        ACT_FAILED        = 4'd12,
        ACT_JAMMED        = 4'd13,
        ACT_SCOUT_DISCARD = 4'd14,
        ACT_IDLE          = 4'd15
    } t_action;

    // compare results worked out at the front
    typedef struct packed {
        logic len_lt_full;
        logic len_lt_short;
        logic len_eq_short;
        logic dst_bcast;
        logic dst_mine;
        logic port_imm;
        logic port_ip;
        logic ctl_peek;
        logic stn_bcast;
    } t_flags;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] dst;
        logic [15:0] src;
        logic [7:0]  port;
        logic [7:0]  ctl;
        logic [15:0] len;
        logic [7:0]  retries;
        logic        line_free;
        t_flags      flags;
    } t_item;

endpackage

>>> rtl/ehe_if.sv
// ----------------------------------------------------------------------------
// ehe channel interfaces
// valid/ready channels for request words and action words
// ----------------------------------------------------------------------------
interface ehe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] frame_dst;
    logic [15:0] frame_src;
    logic [7:0]  frame_port;
    logic [7:0]  frame_control;
    logic [15:0] frame_len;
    logic [7:0]  tx_retries_left;
    logic        line_free;

    modport source (
        output valid, req_type, frame_dst, frame_src, frame_port, frame_control,
               frame_len, tx_retries_left, line_free,
        input  ready
    );
    modport sink (
        input  valid, req_type, frame_dst, frame_src, frame_port, frame_control,
               frame_len, tx_retries_left, line_free,
        output ready
    );
endinterface

interface ehe_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [15:0] out_dst;
    logic [15:0] out_src;
    logic [7:0]  out_port;
    logic [7:0]  out_control;
    logic [15:0] out_len;
    logic [31:0] peek_reply;
    logic [7:0]  retries_left;
    logic [2:0]  state_now;

    modport source (
        output valid, action, out_dst, out_src, out_port, out_control, out_len,
               peek_reply, retries_left, state_now,
        input  ready
    );
    modport sink (
        input  valid, action, out_dst, out_src, out_port, out_control, out_len,
               peek_reply, retries_left, state_now,
        output ready
    );
endinterface

>>> rtl/ehe_front.sv
// ----------------------------------------------------------------------------
// ehe_front
// config registers and request word classification
// ----------------------------------------------------------------------------
module ehe_front
    import ehe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ehe_in_if.sink            i_in,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_q_ready,
    output logic              o_push,
    output t_item             o_item,
    output logic [15:0]       o_my_address
);

    logic [15:0] r_my_address;
    logic [7:0]  r_ip_port;
    logic [7:0]  r_imm_port;
    logic [7:0]  r_peek_ctl;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_address <= MY_ADDR_RST;
            r_ip_port    <= IP_PORT_RST;
            r_imm_port   <= IMM_PORT_RST;
            r_peek_ctl   <= PEEK_CTL_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MY_ADDR:  r_my_address <= pwdata[15:0];
                REG_IP_PORT:  r_ip_port    <= pwdata[7:0];
                REG_IMM_PORT: r_imm_port   <= pwdata[7:0];
                REG_PEEK_CTL: r_peek_ctl   <= pwdata[7:0];
                default:      r_my_address <= r_my_address;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MY_ADDR:  prdata = {16'd0, r_my_address};
            REG_IP_PORT:  prdata = {24'd0, r_ip_port};
            REG_IMM_PORT: prdata = {24'd0, r_imm_port};
            REG_PEEK_CTL: prdata = {24'd0, r_peek_ctl};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_my_address = r_my_address;

    // word moves straight into the queue when there is room, none in reset
    assign i_in.ready = i_q_ready && i_rst_n;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_item.req_type           = i_in.req_type;
        o_item.dst                = i_in.frame_dst;
        o_item.src                = i_in.frame_src;
        o_item.port               = i_in.frame_port;
        o_item.ctl                = i_in.frame_control;
        o_item.len                = i_in.frame_len;
        o_item.retries            = i_in.tx_retries_left;
        o_item.line_free          = i_in.line_free;
        o_item.flags.len_lt_full  = i_in.frame_len < FULL_HDR_LEN;
        o_item.flags.len_lt_short = i_in.frame_len < SHORT_HDR_LEN;
        o_item.flags.len_eq_short = i_in.frame_len == SHORT_HDR_LEN;
        o_item.flags.dst_bcast    = i_in.frame_dst == BCAST_ADDR;
        o_item.flags.dst_mine     = i_in.frame_dst == r_my_address;
        o_item.flags.port_imm     = i_in.frame_port == r_imm_port;
        o_item.flags.port_ip      = i_in.frame_port == r_ip_port;
        o_item.flags.ctl_peek     = i_in.frame_control == r_peek_ctl;
        o_item.flags.stn_bcast    = i_in.frame_dst[7:0] == STATION_BCAST;
    end

endmodule

>>> rtl/ehe_queue.sv
// ----------------------------------------------------------------------------
// ehe_queue
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
`include "econet_handshake_engine_defines.svh"

module ehe_queue
    import ehe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `EHE_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, r_count == 2'd2, !i_push, "push into full queue")
    `EHE_ASSERT_NOW(a_q_no_underflow, i_clk, i_rst_n, r_count == 2'd0, !i_pop, "pop from empty queue")
    `EHE_ASSERT_NOW(a_q_ptr_match, i_clk, i_rst_n, r_count == 2'd0 || r_count == 2'd2, r_wptr == r_rptr, "queue pointers disagree with count")

endmodule

>>> rtl/ehe_back.sv
// ----------------------------------------------------------------------------
// ehe_back
// handshake state machine with held header and action word register
// ----------------------------------------------------------------------------
`include "econet_handshake_engine_defines.svh"

module ehe_back
    import ehe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [15:0] i_my_address,
    ehe_out_if.source   o_out
);

    t_state      r_state, n_state;
    logic [15:0] r_held_dst, n_held_dst;
    logic [15:0] r_held_src, n_held_src;
    logic [7:0]  r_held_port, n_held_port;
    logic [7:0]  r_held_ctl, n_held_ctl;
    logic [15:0] r_held_len, n_held_len;
    logic [7:0]  r_held_retries, n_held_retries;
    logic        r_held_tagged, n_held_tagged;

    logic        r_out_valid;
    t_action     r_act, n_act;
    logic [15:0] r_dst, n_dst;
    logic [15:0] r_src, n_src;
    logic [7:0]  r_port, n_port;
    logic [7:0]  r_ctl, n_ctl;
    logic [15:0] r_len, n_len;
    logic [31:0] r_peek, n_peek;
    logic [7:0]  r_retries, n_retries;

    logic [16:0] w_sum;
    logic [15:0] w_deliver_len;
    logic [15:0] w_data_len;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    assign w_sum         = {1'b0, r_held_len} + {1'b0, i_item.len} - {1'b0, SHORT_HDR_LEN};
    assign w_deliver_len = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    assign w_data_len    = (r_held_len > FULL_HDR_LEN)
                         ? r_held_len - (FULL_HDR_LEN - SHORT_HDR_LEN) : SHORT_HDR_LEN;

    always_comb begin
        n_state        = r_state;
        n_held_dst     = r_held_dst;
        n_held_src     = r_held_src;
        n_held_port    = r_held_port;
        n_held_ctl     = r_held_ctl;
        n_held_len     = r_held_len;
        n_held_retries = r_held_retries;
        n_held_tagged  = r_held_tagged;
        n_act          = ACT_IGNORED;
        n_dst          = 16'd0;
        n_src          = 16'd0;
        n_port         = 8'd0;
        n_ctl          = 8'd0;
        n_len          = 16'd0;
        n_peek         = 32'd0;
        n_retries      = 8'd0;
        unique case (t_req'(i_item.req_type))
            REQ_FRAME: begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (i_item.flags.len_lt_full) begin
                            n_act = ACT_DROP;
                        end else if (i_item.flags.dst_bcast) begin
                            n_act  = ACT_DELIVER_BCAST;
                            n_dst  = i_item.dst;
                            n_src  = i_item.src;
                            n_port = i_item.port;
                            n_ctl  = i_item.ctl;
                            n_len  = i_item.len;
                        end else if (i_item.flags.dst_mine && i_item.flags.port_imm) begin
                            if (i_item.flags.ctl_peek) begin
                                n_act  = ACT_PEEK_REPLY;
                                n_dst  = i_item.src;
                                n_src  = i_my_address;
                                n_len  = PEEK_LEN;
                                n_peek = PEEK_DATA;
                            end else begin
                                n_act = ACT_DROP;
                            end
                        end else if (i_item.flags.dst_mine && i_item.flags.port_ip) begin
                            n_act       = ACT_ACK;
                            n_dst       = i_item.src;
                            n_src       = i_my_address;
                            n_len       = SHORT_HDR_LEN;
                            n_held_dst  = i_item.dst;
                            n_held_src  = i_item.src;
                            n_held_port = i_item.port;
                            n_held_ctl  = i_item.ctl;
                            n_held_len  = i_item.len;
                            n_state     = ST_SCOUT_RCVD;
                        end else begin
                            n_act = ACT_DROP;
                        end
                    end
                    ST_SCOUT_RCVD: begin
                        if (i_item.flags.len_lt_short || i_item.src != r_held_src
                            || i_item.dst != r_held_dst) begin
                            n_act = ACT_DROP;
                        end else begin
                            n_act   = ACT_DELIVER_PKT;
                            n_dst   = r_held_dst;
                            n_src   = r_held_src;
                            n_port  = r_held_port;
                            n_ctl   = r_held_ctl;
                            n_len   = w_deliver_len;
                            n_state = ST_DONE;
                        end
                    end
                    ST_SCOUT_SENT, ST_DATA_SENT: begin
                        if (!i_item.flags.len_eq_short || i_item.src != r_held_dst
                            || i_item.dst != r_held_src) begin
                            n_act = ACT_DROP;
                        end else if (r_state == ST_SCOUT_SENT) begin
                            n_act   = ACT_DATA;
                            n_dst   = r_held_dst;
                            n_src   = r_held_src;
                            n_len   = w_data_len;
                            n_state = ST_DATA_SENT;
                        end else begin
                            n_act   = ACT_COMPLETE;
                            n_dst   = r_held_dst;
                            n_src   = r_held_src;
                            n_port  = r_held_port;
                            n_ctl   = r_held_ctl;
                            n_len   = r_held_len;
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        n_act = ACT_DROP;
                    end
                endcase
            end
            REQ_IDLE: begin
                unique case (r_state)
                    ST_SCOUT_SENT, ST_DATA_SENT: begin
                        if (!r_held_tagged) begin
                            n_act = ACT_DROP;
                        end else begin
                            n_act  = (r_held_retries > 8'd1) ? ACT_RETRY : ACT_FAILED;
                            n_dst  = r_held_dst;
                            n_src  = r_held_src;
                            n_port = r_held_port;
                            n_ctl  = r_held_ctl;
                            n_len  = r_held_len;
                            n_retries = (r_held_retries > 8'd1)
                                      ? r_held_retries - 8'd1 : 8'd0;
                        end
                    end
                    ST_IMMED_SENT: n_act = ACT_DROP;
                    ST_SCOUT_RCVD: n_act = ACT_SCOUT_DISCARD;
                    default:       n_act = ACT_IDLE;
                endcase
                n_state = ST_IDLE;
            end
            REQ_TX: begin
                if (r_state != ST_IDLE) begin
                    n_act = ACT_IGNORED;
                end else if (!i_item.line_free) begin
                    n_act = ACT_JAMMED;
                end else begin
                    n_dst  = i_item.dst;
                    n_src  = i_item.src;
                    n_port = i_item.port;
                    n_ctl  = i_item.ctl;
                    n_len  = i_item.len;
                    if (i_item.flags.port_imm) begin
                        n_act   = ACT_IMMEDIATE;
                        n_state = ST_IMMED_SENT;
                    end else if (i_item.flags.stn_bcast) begin
                        n_act   = ACT_BCAST;
                        n_state = ST_DONE;
                    end else begin
                        n_act          = ACT_SCOUT;
                        n_len          = FULL_HDR_LEN;
                        n_held_dst     = i_item.dst;
                        n_held_src     = i_item.src;
                        n_held_port    = i_item.port;
                        n_held_ctl     = i_item.ctl;
                        n_held_len     = i_item.len;
                        n_held_retries = i_item.retries;
                        n_held_tagged  = 1'b1;
                        n_state        = ST_SCOUT_SENT;
                    end
                end
            end
            default: begin
                n_act = ACT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_UNKNOWN;
            r_held_dst     <= 16'd0;
            r_held_src     <= 16'd0;
            r_held_port    <= 8'd0;
            r_held_ctl     <= 8'd0;
            r_held_len     <= 16'd0;
            r_held_retries <= 8'd0;
            r_held_tagged  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state        <= n_state;
                r_held_dst     <= n_held_dst;
                r_held_src     <= n_held_src;
                r_held_port    <= n_held_port;
                r_held_ctl     <= n_held_ctl;
                r_held_len     <= n_held_len;
                r_held_retries <= n_held_retries;
                r_held_tagged  <= n_held_tagged;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act     <= n_act;
            r_dst     <= n_dst;
            r_src     <= n_src;
            r_port    <= n_port;
            r_ctl     <= n_ctl;
            r_len     <= n_len;
            r_peek    <= n_peek;
            r_retries <= n_retries;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.action       = r_act;
    assign o_out.out_dst      = r_dst;
    assign o_out.out_src      = r_src;
    assign o_out.out_port     = r_port;
    assign o_out.out_control  = r_ctl;
    assign o_out.out_len      = r_len;
    assign o_out.peek_reply   = r_peek;
    assign o_out.retries_left = r_retries;
    assign o_out.state_now    = r_state;

    `EHE_ASSERT_NEXT(a_idle_ends_idle, i_clk, i_rst_n, o_pop && i_item.req_type == REQ_IDLE, r_state == ST_IDLE, "line idle did not end in idle")
    `EHE_ASSERT_NEXT(a_busy_tx_ignored, i_clk, i_rst_n, o_pop && i_item.req_type == REQ_TX && r_state != ST_IDLE, r_state == $past(r_state) && r_act == ACT_IGNORED, "request taken while busy")
    `EHE_ASSERT_NOW(a_sent_is_tagged, i_clk, i_rst_n, r_state == ST_SCOUT_SENT || r_state == ST_DATA_SENT, r_held_tagged, "sending without a held request")

endmodule

>>> rtl/econet_handshake_engine.sv
// ----------------------------------------------------------------------------
// econet_handshake_engine
// station side of the econet four-way handshake, one action word per request
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake            | word
//  ----------+-----+----------------------+-----------------------------------
//  i_in      | in  | valid/ready          | frame header, line idle or tx req
//  o_out     | out | valid/ready          | action, header, peek data, state
//  apb       | in  | psel/penable/pwrite  | four config registers at 4*i
//
//  one word per clock sustained while o_out is not stalled; a request word
//  that is taken fills the queue, and the action register is then loaded from
//  the queue head, so an action word reaches o_out through both registers
//  the state machine in the back end decides combinationally and updates with the action register
//  synchronous active-low reset returns to unknown state and default config;
//  i_in.ready stays low while reset is held
//  a stalled output holds the action register; the two-entry queue keeps the
//  input open until it fills, then i_in.ready drops
//
module econet_handshake_engine
    import ehe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ehe_in_if.sink            i_in,
    ehe_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // front to queue
    logic        w_push;
    logic        w_q_ready;
    t_item       w_front_item;
    logic [15:0] w_my_address;

    // queue to back
    logic        w_q_valid;
    logic        w_pop;
    t_item       w_back_item;

    // front: config registers plus the address/port/control/length flag compares
    ehe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_q_ready    (w_q_ready),
        .o_push       (w_push),
        .o_item       (w_front_item),
        .o_my_address (w_my_address)
    );

    // short queue so front and back stall independently
    ehe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_back_item),
        .i_pop   (w_pop)
    );

    // back: protocol state, held header, action register
    ehe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_item       (w_back_item),
        .o_pop        (w_pop),
        .i_my_address (w_my_address),
        .o_out        (o_out)
    );

endmodule

>>> sim/econet_handshake_engine_tb.sv
// ----------------------------------------------------------------------------
// econet_handshake_engine_tb
// Self-checking bench for the station-side four-way handshake engine.
// A model of the handshake state machine predicts one action word per
// request word. A checker compares every accepted action word against the
// oldest prediction. Directed words come first. Four randomized traffic
// phases follow, one per idling mix, each with its own register setting.
// A long receiver hold-off fills the engine and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module econet_handshake_engine_tb;
    import ehe_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int TIMEOUT_NS = 2_000_000;

    // request word as the sender drives it
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] dst;
        logic [15:0] src;
        logic [7:0]  port;
        logic [7:0]  ctl;
        logic [15:0] len;
        logic [7:0]  retries;
        logic        line_free;
    } t_hdr_word;

    // action word as the engine should return it
    typedef struct packed {
        t_action     act;
        logic [15:0] dst;
        logic [15:0] src;
        logic [7:0]  port;
        logic [7:0]  ctl;
        logic [15:0] len;
        logic [31:0] peek;
        logic [7:0]  retries;
        t_state      st;
    } t_action_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    ehe_in_if  in_ch ();
    ehe_out_if out_ch ();

    econet_handshake_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model copy of the config registers, reset values
    logic [15:0] cfg_my_addr  = MY_ADDR_RST;
    logic [7:0]  cfg_ip_port  = IP_PORT_RST;
    logic [7:0]  cfg_imm_port = IMM_PORT_RST;
    logic [7:0]  cfg_peek_ctl = PEEK_CTL_RST;

    // model copy of the handshake state and the held header
    t_state      eng_state    = ST_UNKNOWN;
    logic [15:0] held_dst     = '0;
    logic [15:0] held_src     = '0;
    logic [7:0]  held_port    = '0;
    logic [7:0]  held_ctl     = '0;
    logic [15:0] held_len     = '0;
    logic [7:0]  held_retries = '0;
    logic        held_tagged  = 1'b0;

    // predicted action words, oldest first
    t_action_word pending_actions[$];

    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;

    // ------------------------------------------------------------------------
    // handshake model
    // ------------------------------------------------------------------------

    // action word carrying a header, every other field zero
    function automatic t_action_word action_hdr(input t_action a,
                                                input logic [15:0] dst, src,
                                                input logic [7:0] port, ctl,
                                                input logic [15:0] len);
        t_action_word r;
        r      = '0;
        r.act  = a;
        r.dst  = dst;
        r.src  = src;
        r.port = port;
        r.ctl  = ctl;
        r.len  = len;
        return r;
    endfunction

    // works out the action for one accepted word and advances the model
    function automatic t_action_word predict_action(input t_hdr_word w);
        t_action_word r;
        logic [16:0]  sum;
        r = action_hdr(ACT_IGNORED, '0, '0, '0, '0, '0);
        case (w.req_type)
            REQ_FRAME: begin
                r = action_hdr(ACT_DROP, '0, '0, '0, '0, '0);
                case (eng_state)
                    ST_IDLE: begin
                        // anything shorter than a full header is dropped
                        if (w.len >= FULL_HDR_LEN) begin
                            if (w.dst == BCAST_ADDR) begin
                                r = action_hdr(ACT_DELIVER_BCAST, w.dst, w.src,
                                               w.port, w.ctl, w.len);
                            end else if (w.dst == cfg_my_addr &&
                                         w.port == cfg_imm_port) begin
                                // immediate port wins over the ip port
                                if (w.ctl == cfg_peek_ctl) begin
                                    r = action_hdr(ACT_PEEK_REPLY, w.src, cfg_my_addr,
                                                   '0, '0, PEEK_LEN);
                                    r.peek = PEEK_DATA;
                                end
                            end else if (w.dst == cfg_my_addr &&
                                         w.port == cfg_ip_port) begin
                                r = action_hdr(ACT_ACK, w.src, cfg_my_addr, '0, '0,
                                               SHORT_HDR_LEN);
                                held_dst  = w.dst;
                                held_src  = w.src;
                                held_port = w.port;
                                held_ctl  = w.ctl;
                                held_len  = w.len;
                                eng_state = ST_SCOUT_RCVD;
                            end
                        end
                    end
                    ST_SCOUT_RCVD: begin
                        if (w.len >= SHORT_HDR_LEN && w.src == held_src &&
                            w.dst == held_dst) begin
                            // payload adds to the scout length, saturating
                            sum = {1'b0, held_len} + {1'b0, w.len} - {1'b0, SHORT_HDR_LEN};
                            if (sum > 17'h0FFFF) sum = 17'h0FFFF;
                            r = action_hdr(ACT_DELIVER_PKT, held_dst, held_src,
                                           held_port, held_ctl, sum[15:0]);
                            eng_state = ST_DONE;
                        end
                    end
                    ST_SCOUT_SENT, ST_DATA_SENT: begin
                        if (w.len == SHORT_HDR_LEN && w.src == held_dst &&
                            w.dst == held_src) begin
                            if (eng_state == ST_SCOUT_SENT) begin
                                // data frame: short header plus payload past the
                                // full header, none when the packet is shorter
                                sum = {1'b0, SHORT_HDR_LEN};
                                if (held_len > FULL_HDR_LEN)
                                    sum = sum + {1'b0, held_len - FULL_HDR_LEN};
                                r = action_hdr(ACT_DATA, held_dst, held_src, '0, '0,
                                               sum[15:0]);
                                eng_state = ST_DATA_SENT;
                            end else begin
                                r = action_hdr(ACT_COMPLETE, held_dst, held_src,
                                               held_port, held_ctl, held_len);
                                eng_state = ST_DONE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            REQ_IDLE: begin
                case (eng_state)
                    ST_SCOUT_SENT, ST_DATA_SENT: begin
                        if (!held_tagged) begin
                            r = action_hdr(ACT_DROP, '0, '0, '0, '0, '0);
                        end else if (held_retries > 8'd1) begin
                            r = action_hdr(ACT_RETRY, held_dst, held_src, held_port,
                                           held_ctl, held_len);
                            r.retries = held_retries - 8'd1;
                        end else begin
                            r = action_hdr(ACT_FAILED, held_dst, held_src, held_port,
                                           held_ctl, held_len);
                        end
                    end
                    // an immediate that meets idle is dropped without retry
                    ST_IMMED_SENT: r = action_hdr(ACT_DROP, '0, '0, '0, '0, '0);
                    ST_SCOUT_RCVD: r = action_hdr(ACT_SCOUT_DISCARD, '0, '0, '0, '0, '0);
                    default:       r = action_hdr(ACT_IDLE, '0, '0, '0, '0, '0);
                endcase
                eng_state = ST_IDLE;
            end
            REQ_TX: begin
                // outside idle the request is ignored and nothing changes
                if (eng_state == ST_IDLE) begin
                    if (!w.line_free) begin
                        r = action_hdr(ACT_JAMMED, '0, '0, '0, '0, '0);
                    end else if (w.port == cfg_imm_port) begin
                        r = action_hdr(ACT_IMMEDIATE, w.dst, w.src, w.port, w.ctl, w.len);
                        eng_state = ST_IMMED_SENT;
                    end else if (w.dst[7:0] == STATION_BCAST) begin
                        r = action_hdr(ACT_BCAST, w.dst, w.src, w.port, w.ctl, w.len);
                        eng_state = ST_DONE;
                    end else begin
                        r = action_hdr(ACT_SCOUT, w.dst, w.src, w.port, w.ctl,
                                       FULL_HDR_LEN);
                        held_dst     = w.dst;
                        held_src     = w.src;
                        held_port    = w.port;
                        held_ctl     = w.ctl;
                        held_len     = w.len;
                        held_retries = w.retries;
                        held_tagged  = 1'b1;
                        eng_state    = ST_SCOUT_SENT;
                    end
                end
            end
            default: begin
                // unknown request type is ignored
            end
        endcase
        r.st = eng_state;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_hdr_word mk_word(input logic [1:0] rt,
                                          input logic [15:0] dst, src,
                                          input logic [7:0] port, ctl,
                                          input logic [15:0] len,
                                          input logic [7:0] retries,
                                          input logic free);
        t_hdr_word w;
        w.req_type  = rt;
        w.dst       = dst;
        w.src       = src;
        w.port      = port;
        w.ctl       = ctl;
        w.len       = len;
        w.retries   = retries;
        w.line_free = free;
        return w;
    endfunction

    // lengths clustered around the header thresholds, with the far ends too
    function automatic logic [15:0] rand_len();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 8));
            1:       return 16'($urandom);
            2:       return 16'hFFFF - 16'($urandom_range(0, 2));
            default: return 16'($urandom_range(6, 300));
        endcase
    endfunction

    function automatic logic [7:0] rand_retries();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 2));
            1:       return 8'd16;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly a word that moves the handshake forward from the model state,
    // sometimes pure noise
    function automatic t_hdr_word gen_word();
        t_hdr_word w;
        int        pick;
        w.req_type  = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        w.dst       = 16'($urandom);
        w.src       = 16'($urandom);
        w.port      = 8'($urandom);
        w.ctl       = 8'($urandom);
        w.len       = rand_len();
        w.retries   = rand_retries();
        w.line_free = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 20) return w;
        pick = $urandom_range(0, 99);
        case (eng_state)
            ST_IDLE: begin
                w.line_free = 1'b1;
                if (pick < 30) begin
                    // unicast send, starts the four-way exchange
                    w.req_type = REQ_TX;
                    if (w.dst[7:0] == STATION_BCAST) w.dst[7:0] = 8'h01;
                    if (w.port == cfg_imm_port) w.port = cfg_imm_port + 8'd1;
                end else if (pick < 38) begin
                    w.req_type = REQ_TX;
                    w.port     = cfg_imm_port;
                end else if (pick < 45) begin
                    w.req_type  = REQ_TX;
                    w.dst[7:0]  = STATION_BCAST;
                    if (w.port == cfg_imm_port) w.port = cfg_imm_port + 8'd1;
                end else if (pick < 50) begin
                    w.req_type  = REQ_TX;
                    w.line_free = 1'b0;
                end else if (pick < 75) begin
                    // incoming scout for us
                    w.req_type = REQ_FRAME;
                    w.dst      = cfg_my_addr;
                    w.port     = cfg_ip_port;
                    if ($urandom_range(0, 3) != 0 && w.len < FULL_HDR_LEN)
                        w.len = FULL_HDR_LEN;
                end else if (pick < 85) begin
                    // machine peek, or another immediate op
                    w.req_type = REQ_FRAME;
                    w.dst      = cfg_my_addr;
                    w.port     = cfg_imm_port;
                    if ($urandom_range(0, 2) != 0) w.ctl = cfg_peek_ctl;
                    if ($urandom_range(0, 3) != 0 && w.len < FULL_HDR_LEN)
                        w.len = FULL_HDR_LEN;
                end else if (pick < 92) begin
                    w.req_type = REQ_FRAME;
                    w.dst      = BCAST_ADDR;
                end else begin
                    w.req_type = REQ_IDLE;
                end
            end
            ST_SCOUT_RCVD: begin
                if (pick < 85) begin
                    // data frame following the scout
                    w.req_type = REQ_FRAME;
                    w.dst      = held_dst;
                    w.src      = held_src;
                    if (pick < 75 && w.len < SHORT_HDR_LEN) w.len = SHORT_HDR_LEN;
                end else begin
                    w.req_type = REQ_IDLE;
                end
            end
            ST_SCOUT_SENT, ST_DATA_SENT: begin
                if (pick < 80) begin
                    // ack from the far station
                    w.req_type = REQ_FRAME;
                    w.src      = held_dst;
                    w.dst      = held_src;
                    if (pick < 72) w.len = SHORT_HDR_LEN;
                end else begin
                    // line goes idle mid-exchange: retry or failed
                    w.req_type = REQ_IDLE;
                end
            end
            default: begin
                if (pick < 85) w.req_type = REQ_IDLE;
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offers one request word, waits for the handshake, records the prediction
    task automatic send_word(input t_hdr_word w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.req_type        <= w.req_type;
        in_ch.frame_dst       <= w.dst;
        in_ch.frame_src       <= w.src;
        in_ch.frame_port      <= w.port;
        in_ch.frame_control   <= w.ctl;
        in_ch.frame_len       <= w.len;
        in_ch.tx_retries_left <= w.retries;
        in_ch.line_free       <= w.line_free;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_actions.push_back(predict_action(w));
    endtask

    // stop offering and wait until every predicted action word came back
    task automatic wait_drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge i_clk);
    endtask

    // apb write: setup cycle then access cycle; only called while drained
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MY_ADDR:  cfg_my_addr  = value[15:0];
            REG_IP_PORT:  cfg_ip_port  = value[7:0];
            REG_IMM_PORT: cfg_imm_port = value[7:0];
            REG_PEEK_CTL: cfg_peek_ctl = value[7:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: a requested hold-off first, then random stalls
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_actions
        t_action_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_actions.size() == 0) begin
                $error("action word with nothing pending: action=%0d", out_ch.action);
                fail_count++;
            end else begin
                exp_w = pending_actions.pop_front();
                check_field("action",       32'(exp_w.act),     32'(out_ch.action));
                check_field("out_dst",      32'(exp_w.dst),     32'(out_ch.out_dst));
                check_field("out_src",      32'(exp_w.src),     32'(out_ch.out_src));
                check_field("out_port",     32'(exp_w.port),    32'(out_ch.out_port));
                check_field("out_control",  32'(exp_w.ctl),     32'(out_ch.out_control));
                check_field("out_len",      32'(exp_w.len),     32'(out_ch.out_len));
                check_field("peek_reply",   exp_w.peek,         out_ch.peek_reply);
                check_field("retries_left", 32'(exp_w.retries), 32'(out_ch.retries_left));
                check_field("state_now",    32'(exp_w.st),      32'(out_ch.state_now));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // walks every action at least once with the reset register values
    // (my address 0, ip port 210, immediate port 0, peek control 136)
    task automatic test_directed();
        // before the first idle the state is unknown
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0101, 8'd210, 8'h00, 16'd6, 8'd0, 1'b0));
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd5, 8'h00, 16'd20, 8'd16, 1'b1));
        // unknown request type, all bits set
        send_word(mk_word(2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // wire not claimed
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd5, 8'h00, 16'd20, 8'd16, 1'b0));
        // broadcast one byte short of a full header, then a full one
        send_word(mk_word(REQ_FRAME, 16'hFFFF, 16'h0203, 8'h99, 8'h80, 16'd5, 8'd0, 1'b0));
        send_word(mk_word(REQ_FRAME, 16'hFFFF, 16'h0203, 8'h99, 8'h80, 16'd6, 8'd0, 1'b0));
        // machine peek, then an immediate op with another control byte
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0304, 8'd0, 8'd136, 16'd6, 8'd0, 1'b0));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0304, 8'd0, 8'd137, 16'd6, 8'd0, 1'b0));
        // longest scout in, short data dropped, then data that saturates
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0405, 8'd210, 8'h80, 16'hFFFF, 8'd0,
                          1'b0));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0405, 8'd0, 8'd0, 16'd3, 8'd0, 1'b0));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0405, 8'd0, 8'd0, 16'hFFFF, 8'd0, 1'b0));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // scout in, then the line goes idle before data
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0405, 8'd210, 8'h81, 16'd6, 8'd0, 1'b0));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // full send of a packet shorter than a full header
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd5, 8'h81, 16'd3, 8'd1, 1'b1));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0102, 8'd0, 8'd0, 16'd5, 8'd0, 1'b0));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0102, 8'd0, 8'd0, 16'd4, 8'd0, 1'b0));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0102, 8'd0, 8'd0, 16'd4, 8'd0, 1'b0));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // idle right after the scout goes out: retry
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd5, 8'h82, 16'd1000, 8'd2, 1'b1));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // no attempts left, idle after data: failed
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd5, 8'h82, 16'd1000, 8'd0, 1'b1));
        send_word(mk_word(REQ_FRAME, 16'h0000, 16'h0102, 8'd0, 8'd0, 16'd4, 8'd0, 1'b0));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // immediate send dropped on idle without retry
        send_word(mk_word(REQ_TX, 16'h0102, 16'h0000, 8'd0, 8'h83, 16'd10, 8'd16, 1'b1));
        send_word(mk_word(REQ_IDLE, '0, '0, '0, '0, '0, '0, 1'b0));
        // station broadcast send
        send_word(mk_word(REQ_TX, 16'h12FF, 16'h0000, 8'd7, 8'h84, 16'd40, 8'd16, 1'b1));
    endtask

    // one register setting and one idling mix, then random traffic
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [15:0] my_addr,
                                       input logic [7:0] ip_port, imm_port, peek_ctl,
                                       input int count);
        wait_drain();
        apb_write(REG_MY_ADDR,  {16'h0000, my_addr});
        apb_write(REG_IP_PORT,  {24'h000000, ip_port});
        apb_write(REG_IMM_PORT, {24'h000000, imm_port});
        apb_write(REG_PEEK_CTL, {24'h000000, peek_ctl});
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_word(gen_word());
    endtask

    // receiver holds off while the sender keeps offering: the engine fills
    // up and must drop i_in.ready without losing a word
    task automatic test_backpressure();
        wait_drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 60;
        repeat (24) send_word(gen_word());
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial begin
        // every input known from time zero
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.req_type        = '0;
        in_ch.frame_dst       = '0;
        in_ch.frame_src       = '0;
        in_ch.frame_port      = '0;
        in_ch.frame_control   = '0;
        in_ch.frame_len       = '0;
        in_ch.tx_retries_left = '0;
        in_ch.line_free       = 1'b0;
        out_ch.ready          = 1'b0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        // phase with no idling, random registers
        test_random_traffic(0, 0, 16'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 280);
        // sender mostly idle, top register values but the immediate port at zero
        test_random_traffic(84, 0, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 280);
        // receiver mostly stalling, bottom register values but the immediate port at 0xFF
        test_random_traffic(0, 84, 16'h0000, 8'h00, 8'hFF, 8'h00, 280);
        test_backpressure();
        // light idling on both sides
        test_random_traffic(18, 18, 16'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 280);

        wait_drain();
        // keep clocking so a stray action word would still be caught
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
